### rtl/core/rtu_pkg.sv
// ----------------------------------------------------------------------------
// rtu_pkg: shared types and constants for the RTU response receiver
// Item kinds, result status codes, CSR indexes and the CRC-16 fold.
// ----------------------------------------------------------------------------
package rtu_pkg;

   localparam int FUNC_W   = 2;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 5;
   localparam int TICK_W   = 8;
   localparam int CRC_W    = 16;
   localparam int CSR_IDX_W = 1;

   localparam int MIN_FRAME = 4;   // address + function + two CRC bytes
   localparam int MAX_OUT   = 30;  // cap on payload beats per frame

   localparam logic [CRC_W-1:0]  CRC_INIT      = 16'hFFFF;
   localparam logic [CRC_W-1:0]  CRC_POLY      = 16'hA001;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 8'd100;
   localparam logic [TICK_W-1:0] GAP_RESET     = 8'd30;

   localparam logic [CSR_IDX_W-1:0] CSR_RESP_TIMEOUT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAR_GAP     = 1'd1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ARM  = 2'd0,
      FUNC_BYTE = 2'd1,
      FUNC_TICK = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 3'd0,
      STATUS_OVERRUN = 3'd1,
      STATUS_CRC     = 3'd2,
      STATUS_TIMEOUT = 3'd3,
      STATUS_SHORT   = 3'd4
   } status_type;

   typedef struct packed {
      status_type          status;
      logic [BYTE_W-1:0]   payload_byte;
      logic [INDEX_W-1:0]  byte_index;
      logic                last;
   } rsp_beat_type;

   // CRC-16, reflected polynomial, LSB first
   function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### rtl/core/rtu_req_if.sv
// ----------------------------------------------------------------------------
// rtu_req_if: request channel
// Valid/ready channel carrying one item kind and one received byte per beat.
// ----------------------------------------------------------------------------
interface rtu_req_if;
   logic                        valid;
   logic                        ready;
   logic [rtu_pkg::FUNC_W-1:0]  func;
   logic [rtu_pkg::BYTE_W-1:0]  rx_byte;

   modport source (output valid, output func, output rx_byte, input ready);
   modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

### rtl/core/rtu_rsp_if.sv
// ----------------------------------------------------------------------------
// rtu_rsp_if: response channel
// Valid/ready channel carrying one result beat of a received frame.
// ----------------------------------------------------------------------------
interface rtu_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rtu_pkg::STATUS_W-1:0]  status;
   logic [rtu_pkg::BYTE_W-1:0]    payload_byte;
   logic [rtu_pkg::INDEX_W-1:0]   byte_index;
   logic                          last;

   modport source (output valid, output status, output payload_byte,
                   output byte_index, output last, input ready);
   modport sink   (input valid, input status, input payload_byte,
                   input byte_index, input last, output ready);
endinterface

### rtl/core/rtu_ram.sv
// ----------------------------------------------------------------------------
// rtu_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module rtu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/rtu_out_reg.sv
// ----------------------------------------------------------------------------
// rtu_out_reg: response output register
// Holds one result beat until taken; reloadable in the cycle it drains.
// ----------------------------------------------------------------------------
module rtu_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  rtu_pkg::rsp_beat_type beat,
   output logic                  can_load,
   rtu_rsp_if.source             rsp_bus
);

   logic                  valid_ff;
   logic                  valid_in;
   rtu_pkg::rsp_beat_type beat_ff;

   assign can_load = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= beat;
      end
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.status       = beat_ff.status;
   assign rsp_bus.payload_byte = beat_ff.payload_byte;
   assign rsp_bus.byte_index   = beat_ff.byte_index;
   assign rsp_bus.last         = beat_ff.last;

endmodule

### rtl/core/rtu_response_receiver.sv
// ----------------------------------------------------------------------------
// rtu_response_receiver: Modbus RTU response frame receiver
// Collects one response frame, checks CRC-16 and streams out its payload or one error beat.
// ----------------------------------------------------------------------------
// Arm, byte and tick beats are accepted back to back while the receiver is
// idle and the output register can take a result.
// A byte is written into the frame store and folded into the CRC-16; a tick
// counts the timer down. When the timer expires (or the store fills) the
// frame ends: errors come out as a single beat with last set; a good frame
// is read back from the frame store at one beat per cycle while the output
// is not stalled, N beats with N = min(bytes - 2, 30). The registered
// read port of the frame store sets that pace. No request beat is accepted
// during the payload burst. The store is not cleared after reset; only bytes
// of the current frame are ever read.
// ----------------------------------------------------------------------------
module rtu_response_receiver #(
   parameter int BUFFER_BYTES = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   rtu_req_if.sink                         req_bus,
   rtu_rsp_if.source                       rsp_bus,
   input  logic                            csr_we,
   input  logic [rtu_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rtu_pkg::TICK_W-1:0]      csr_wdata
);

   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int CW = $clog2(BUFFER_BYTES + 1);
   localparam int XW = (CW > rtu_pkg::INDEX_W) ? CW : rtu_pkg::INDEX_W;

   typedef enum logic {
      S_IDLE,
      S_DRAIN
   } state_type;

   // control state
   state_type                       state_ff, state_in;
   logic                            armed_ff, armed_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [rtu_pkg::TICK_W-1:0]      timer_ff, timer_in;
   logic [rtu_pkg::CRC_W-1:0]       crc_ff, crc_in;
   logic [rtu_pkg::INDEX_W-1:0]     idx_ff, idx_in;
   logic [rtu_pkg::INDEX_W-1:0]     last_idx_ff, last_idx_in;

   // CSRs
   logic [rtu_pkg::TICK_W-1:0]      timeout_ff;
   logic [rtu_pkg::TICK_W-1:0]      gap_ff;

   logic                            accept;
   rtu_pkg::func_type               func;
   logic [CW-1:0]                   count_inc;
   logic [rtu_pkg::TICK_W-1:0]      timer_dec;
   logic [XW-1:0]                   n_ext;

   logic                            ram_we;
   logic                            ram_re;
   logic [AW-1:0]                   ram_raddr;
   logic [rtu_pkg::BYTE_W-1:0]      ram_rdata;

   logic                            out_load;
   logic                            out_can_load;
   rtu_pkg::rsp_beat_type           out_beat;

   assign req_bus.ready = (state_ff == S_IDLE) && out_can_load;
   assign accept        = req_bus.valid && req_bus.ready;
   assign func          = rtu_pkg::func_type'(req_bus.func);
   assign count_inc     = count_ff + CW'(1);
   assign timer_dec     = (timer_ff != '0) ? timer_ff - 8'd1 : timer_ff;
   // payload length before capping
   assign n_ext         = XW'(count_ff) - XW'(2);
   assign ram_raddr     = AW'(idx_in);

   always_comb begin
      state_in    = state_ff;
      armed_in    = armed_ff;
      count_in    = count_ff;
      timer_in    = timer_ff;
      crc_in      = crc_ff;
      idx_in      = idx_ff;
      last_idx_in = last_idx_ff;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      out_load    = 1'b0;
      out_beat.status       = rtu_pkg::STATUS_OK;
      out_beat.payload_byte = '0;
      out_beat.byte_index   = '0;
      out_beat.last         = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (func)
                  rtu_pkg::FUNC_ARM: begin
                     // arm also restarts a frame in progress
                     count_in = '0;
                     crc_in   = rtu_pkg::CRC_INIT;
                     timer_in = timeout_ff;
                     armed_in = 1'b1;
                  end
                  rtu_pkg::FUNC_BYTE: begin
                     if (armed_ff) begin
                        ram_we   = 1'b1;
                        count_in = count_inc;
                        crc_in   = rtu_pkg::crc_fold(crc_ff, req_bus.rx_byte);
                        timer_in = gap_ff;
                        if (count_inc == CW'(BUFFER_BYTES)) begin
                           armed_in        = 1'b0;
                           out_load        = 1'b1;
                           out_beat.status = rtu_pkg::STATUS_OVERRUN;
                        end
                     end
                  end
                  rtu_pkg::FUNC_TICK: begin
                     if (armed_ff) begin
                        timer_in = timer_dec;
                        if (timer_dec == '0) begin
                           armed_in = 1'b0;
                           if (count_ff == '0) begin
                              out_load        = 1'b1;
                              out_beat.status = rtu_pkg::STATUS_TIMEOUT;
                           end else if (count_ff < CW'(rtu_pkg::MIN_FRAME)) begin
                              out_load        = 1'b1;
                              out_beat.status = rtu_pkg::STATUS_SHORT;
                           end else if (crc_ff != '0) begin
                              out_load        = 1'b1;
                              out_beat.status = rtu_pkg::STATUS_CRC;
                           end else begin
                              // good frame: prefetch byte 0, then stream
                              state_in = S_DRAIN;
                              idx_in   = '0;
                              ram_re   = 1'b1;
                              if (n_ext > XW'(rtu_pkg::MAX_OUT)) begin
                                 last_idx_in = rtu_pkg::INDEX_W'(rtu_pkg::MAX_OUT - 1);
                              end else begin
                                 last_idx_in = rtu_pkg::INDEX_W'(n_ext - XW'(1));
                              end
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DRAIN: begin
            // read data holds while the output register is stalled
            if (out_can_load) begin
               out_load              = 1'b1;
               out_beat.status       = rtu_pkg::STATUS_OK;
               out_beat.payload_byte = ram_rdata;
               out_beat.byte_index   = idx_ff;
               out_beat.last         = (idx_ff == last_idx_ff);
               if (idx_ff == last_idx_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + 5'd1;
                  ram_re = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         armed_ff <= 1'b0;
         count_ff <= '0;
         timer_ff <= '0;
         crc_ff   <= rtu_pkg::CRC_INIT;
         idx_ff   <= '0;
         last_idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         armed_ff <= armed_in;
         count_ff <= count_in;
         timer_ff <= timer_in;
         crc_ff   <= crc_in;
         idx_ff   <= idx_in;
         last_idx_ff <= last_idx_in;
      end
   end

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= rtu_pkg::TIMEOUT_RESET;
         gap_ff     <= rtu_pkg::GAP_RESET;
      end else if (csr_we) begin
         if (csr_index == rtu_pkg::CSR_RESP_TIMEOUT) begin
            timeout_ff <= csr_wdata;
         end
         if (csr_index == rtu_pkg::CSR_CHAR_GAP) begin
            gap_ff <= csr_wdata;
         end
      end
   end

   rtu_ram #(
      .WIDTH (rtu_pkg::BYTE_W),
      .DEPTH (BUFFER_BYTES)
   ) u_frame_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[AW-1:0]),
      .wdata (req_bus.rx_byte),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   rtu_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (out_load),
      .beat     (out_beat),
      .can_load (out_can_load),
      .rsp_bus  (rsp_bus)
   );

`ifndef ASSERT_OFF
   a_no_req_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |-> !req_bus.ready)
      else $error("request accepted during payload burst");

   a_no_write_in_drain: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_IDLE) && armed_ff)
      else $error("frame store written outside reception");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |-> (idx_ff <= last_idx_ff))
      else $error("drain index past last payload byte");

   a_last_ends_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN && out_load && out_beat.last) |=> (state_ff == S_IDLE))
      else $error("burst continued after last beat");

   a_result_disarms: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && out_load) |=> !armed_ff)
      else $error("receiver still armed after frame result");
`endif

endmodule

### tb/rtu_response_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtu_response_receiver_tb: self-checking bench for the RTU response receiver
// Drives arm, byte and tick beats, mirrors the receiver's frame state, CRC and
// timer in a local predictor, and checks every result beat against it.
// ----------------------------------------------------------------------------
module rtu_response_receiver_tb;

   localparam int FRAME_BUF_BYTES = 32;    // store depth, overrun on the last byte
   localparam int SETTLE_CYCLES   = 40;    // payload burst length plus margin
   localparam int HOLD_CYCLES     = 300;   // long result-side hold-off
   localparam int DRAIN_LIMIT     = 20000; // cycles allowed for results to drain
   localparam int REPORT_LIMIT    = 10;

   // func code the block does not use; must be ignored
   localparam logic [rtu_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [rtu_pkg::CSR_IDX_W-1:0] csr_index;
   logic [rtu_pkg::TICK_W-1:0] csr_wdata;

   rtu_req_if req_ch ();
   rtu_rsp_if rsp_ch ();

   rtu_response_receiver #(
      .BUFFER_BYTES (FRAME_BUF_BYTES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_ch),
      .rsp_bus   (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor state: a copy of the receiver's registers and frame state.
   // Updated at the clock edge where a beat or a CSR write is taken.
   // ------------------------------------------------------------------------
   logic [rtu_pkg::TICK_W-1:0] timeout_cfg = rtu_pkg::TIMEOUT_RESET;
   logic [rtu_pkg::TICK_W-1:0] gap_cfg     = rtu_pkg::GAP_RESET;
   logic [rtu_pkg::BYTE_W-1:0] frame_buf [FRAME_BUF_BYTES];
   int                         rx_count    = 0;
   logic [rtu_pkg::TICK_W-1:0] tick_cnt    = '0;
   logic [rtu_pkg::CRC_W-1:0]  crc_acc     = rtu_pkg::CRC_INIT;
   bit                         receiving   = 1'b0;

   rtu_pkg::rsp_beat_type frame_beats [$];   // result beats still owed by the block
   int work_items     = 0;          // beats that changed receiver state
   int mismatch_count = 0;

   // idle rates, percent of cycles
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // long hold-off handshake: main bumps hold_ask, receiver serves it
   int hold_ask  = 0;
   int hold_done = 0;
   int hold_left = 0;

   // CRC-16 (0xA001 reflected), one data bit at a time into the feedback
   function automatic logic [rtu_pkg::CRC_W-1:0] crc16_add(
         input logic [rtu_pkg::CRC_W-1:0] acc,
         input logic [rtu_pkg::BYTE_W-1:0] data);
      logic [rtu_pkg::CRC_W-1:0] r;
      logic fb;
      r = acc;
      for (int k = 0; k < rtu_pkg::BYTE_W; k++) begin
         fb = r[0] ^ data[k];
         r  = r >> 1;
         if (fb) r = r ^ rtu_pkg::CRC_POLY;
      end
      return r;
   endfunction

   // error frames end with one beat: zero byte and index, last set
   function automatic void push_error(input rtu_pkg::status_type s);
      rtu_pkg::rsp_beat_type beat;
      beat.status       = s;
      beat.payload_byte = '0;
      beat.byte_index   = '0;
      beat.last         = 1'b1;
      frame_beats.push_back(beat);
   endfunction

   // Work out what one accepted request beat does to the receiver
   function automatic void predict_item(input logic [rtu_pkg::FUNC_W-1:0] f,
                                        input logic [rtu_pkg::BYTE_W-1:0] b);
      rtu_pkg::rsp_beat_type beat;
      int n;
      if (f == rtu_pkg::FUNC_ARM) begin
         // arm always restarts, even mid-frame
         rx_count  = 0;
         crc_acc   = rtu_pkg::CRC_INIT;
         tick_cnt  = timeout_cfg;
         receiving = 1'b1;
         work_items++;
         return;
      end
      if (!receiving || f == FUNC_UNUSED) return;
      work_items++;

      if (f == rtu_pkg::FUNC_BYTE) begin
         if (rx_count < FRAME_BUF_BYTES) frame_buf[rx_count] = b;
         rx_count++;
         crc_acc  = crc16_add(crc_acc, b);
         tick_cnt = gap_cfg;
         if (rx_count >= FRAME_BUF_BYTES) begin
            receiving = 1'b0;
            push_error(rtu_pkg::STATUS_OVERRUN);
         end
         return;
      end

      // tick: a timer already at zero ends the frame without counting
      if (tick_cnt != 0) tick_cnt--;
      if (tick_cnt != 0) return;
      receiving = 1'b0;
      if (rx_count == 0) begin
         push_error(rtu_pkg::STATUS_TIMEOUT);
      end else if (rx_count < rtu_pkg::MIN_FRAME) begin
         push_error(rtu_pkg::STATUS_SHORT);
      end else if (crc_acc != '0) begin
         push_error(rtu_pkg::STATUS_CRC);
      end else begin
         // payload = frame minus the two CRC bytes, in order
         n = rx_count - 2;
         if (n > rtu_pkg::MAX_OUT) n = rtu_pkg::MAX_OUT;
         for (int i = 0; i < n; i++) begin
            beat.status       = rtu_pkg::STATUS_OK;
            beat.payload_byte = (i < FRAME_BUF_BYTES) ? frame_buf[i] : '0;
            beat.byte_index   = rtu_pkg::INDEX_W'(i);
            beat.last         = (i == n - 1);
            frame_beats.push_back(beat);
         end
      end
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("%0t: MISMATCH %s", $realtime, what);
   endtask

   // Compare one accepted result beat with the oldest expected beat
   task automatic check_result_beat();
      rtu_pkg::rsp_beat_type want;
      if (frame_beats.size() == 0) begin
         report_mismatch($sformatf("unexpected beat st=%0d byte=%02h idx=%0d last=%b",
                                   rsp_ch.status, rsp_ch.payload_byte,
                                   rsp_ch.byte_index, rsp_ch.last));
         return;
      end
      want = frame_beats.pop_front();
      if (rsp_ch.status !== want.status || rsp_ch.payload_byte !== want.payload_byte ||
          rsp_ch.byte_index !== want.byte_index || rsp_ch.last !== want.last) begin
         report_mismatch($sformatf(
            "exp st=%0d byte=%02h idx=%0d last=%b, got st=%0d byte=%02h idx=%0d last=%b",
            want.status, want.payload_byte, want.byte_index, want.last,
            rsp_ch.status, rsp_ch.payload_byte, rsp_ch.byte_index, rsp_ch.last));
      end
   endtask

   // Result side: check on every taken beat, then pick next cycle's ready.
   // A pending hold-off request forces ready low while hold_left runs down.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) check_result_beat();
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (hold_ask != hold_done) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         hold_done    <= hold_ask;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Request side helpers
   // ------------------------------------------------------------------------

   // Offer one beat, with random idle cycles ahead of it, and hold it until
   // taken. valid stays high on return so back-to-back beats need no toggle.
   task automatic send_item(input logic [rtu_pkg::FUNC_W-1:0] f,
                            input logic [rtu_pkg::BYTE_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.func    <= f;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_item(f, b);
   endtask

   // Stop offering and wait until every owed result beat has come out,
   // then let a possible payload burst tail settle.
   task automatic drain_results();
      int waited;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (frame_beats.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [rtu_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rtu_pkg::TICK_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == rtu_pkg::CSR_RESP_TIMEOUT) timeout_cfg = val;
      else gap_cfg = val;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // CSRs only change while the receiver is quiet
   task automatic reconfigure(input logic [rtu_pkg::TICK_W-1:0] timeout,
                              input logic [rtu_pkg::TICK_W-1:0] gap);
      drain_results();
      write_reg(rtu_pkg::CSR_RESP_TIMEOUT, timeout);
      write_reg(rtu_pkg::CSR_CHAR_GAP, gap);
   endtask

   // tick until the predicted frame ends (timer expiry)
   task automatic run_out_timer();
      while (receiving) send_item(rtu_pkg::FUNC_TICK, rtu_pkg::BYTE_W'($urandom));
   endtask

   // occasional tick that cannot expire the timer
   task automatic maybe_idle_tick();
      if (receiving && tick_cnt > 1 && $urandom_range(3) == 0)
         send_item(rtu_pkg::FUNC_TICK, rtu_pkg::BYTE_W'($urandom));
   endtask

   // Arm, send body plus its CRC (low byte first), then tick out the gap.
   // corrupt flips one bit on the line, which CRC-16 always catches.
   task automatic send_framed(input logic [rtu_pkg::BYTE_W-1:0] body [$],
                              input bit corrupt);
      logic [rtu_pkg::BYTE_W-1:0] line_bytes [$];
      logic [rtu_pkg::CRC_W-1:0] c;
      int pos;
      c = rtu_pkg::CRC_INIT;
      foreach (body[i]) c = crc16_add(c, body[i]);
      line_bytes = body;
      line_bytes.push_back(c[7:0]);
      line_bytes.push_back(c[15:8]);
      if (corrupt) begin
         pos = $urandom_range(line_bytes.size() - 1);
         line_bytes[pos] = line_bytes[pos] ^ (8'h01 << $urandom_range(7));
      end
      send_item(rtu_pkg::FUNC_ARM, rtu_pkg::BYTE_W'($urandom));
      foreach (line_bytes[i]) begin
         maybe_idle_tick();
         send_item(rtu_pkg::FUNC_BYTE, line_bytes[i]);
      end
      run_out_timer();
   endtask

   // random body; mostly short, sometimes up to the largest good frame
   task automatic send_random_frame(input int len, input bit corrupt);
      logic [rtu_pkg::BYTE_W-1:0] body [$];
      repeat (len) body.push_back(rtu_pkg::BYTE_W'($urandom));
      send_framed(body, corrupt);
   endtask

   function automatic int pick_body_len();
      if ($urandom_range(9) < 7) return $urandom_range(2, 8);
      return $urandom_range(9, FRAME_BUF_BYTES - 3);
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Unarmed bytes/ticks and the unused func are dropped; then one frame
   // under the reset CSR values (100 / 30 ticks).
   task automatic test_reset_defaults();
      send_item(rtu_pkg::FUNC_TICK, 8'h00);
      send_item(rtu_pkg::FUNC_BYTE, 8'hFF);
      send_item(FUNC_UNUSED, 8'h5A);
      send_random_frame(3, 1'b0);
   endtask

   // timeout, too short and bad CRC, each one error beat
   task automatic test_frame_errors();
      reconfigure(8'd2, 8'd1);
      send_item(rtu_pkg::FUNC_ARM, 8'h00);
      run_out_timer();
      send_item(rtu_pkg::FUNC_ARM, 8'h00);
      send_item(rtu_pkg::FUNC_BYTE, 8'h11);
      run_out_timer();
      send_random_frame(2, 1'b1);
   endtask

   // smallest good frame with extreme bytes; arm mid-frame restarts,
   // unused func while armed is dropped
   task automatic test_good_frames();
      send_framed('{8'h00, 8'hFF}, 1'b0);
      send_item(rtu_pkg::FUNC_ARM, 8'h00);
      send_item(rtu_pkg::FUNC_BYTE, 8'hA5);
      send_item(FUNC_UNUSED, 8'hFF);
      send_framed('{8'hFF, 8'h00, 8'h80}, 1'b0);
   endtask

   // gap and timeout of zero: first tick ends the frame without counting
   task automatic test_zero_ticks();
      reconfigure(8'd0, 8'd0);
      send_random_frame(2, 1'b0);
      send_item(rtu_pkg::FUNC_ARM, 8'h00);
      run_out_timer();
   endtask

   // 32nd byte ends the frame with an overrun; later ticks are dropped
   task automatic test_overrun();
      reconfigure(8'd3, 8'd2);
      send_item(rtu_pkg::FUNC_ARM, 8'h00);
      repeat (FRAME_BUF_BYTES) send_item(rtu_pkg::FUNC_BYTE, rtu_pkg::BYTE_W'($urandom));
      send_item(rtu_pkg::FUNC_TICK, 8'h00);
   endtask

   // CSR extremes: longest timeout, then longest gap with shortest timeout, then both shortest
   task automatic test_register_extremes();
      reconfigure(8'd255, 8'd1);
      send_item(rtu_pkg::FUNC_ARM, 8'h00);
      run_out_timer();
      send_random_frame(4, 1'b0);
      reconfigure(8'd1, 8'd255);
      send_random_frame(2, 1'b0);
      reconfigure(8'd1, 8'd1);
      send_random_frame(5, 1'b0);
   endtask

   // Result side holds off while a full frame completes and the next one is
   // offered: the block must back up and stall its request side. Then the
   // sender pauses until every owed beat is out before going on.
   task automatic test_backpressure();
      reconfigure(8'd4, 8'd2);
      hold_ask <= hold_ask + 1;
      send_random_frame(FRAME_BUF_BYTES - 3, 1'b0);
      send_random_frame(6, 1'b0);
      send_random_frame(3, 1'b1);
      drain_results();
      send_random_frame(4, 1'b0);
   endtask

   // one random frame-level scenario, weighted toward good frames
   task automatic run_random_frame();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) begin
         send_random_frame(pick_body_len(), 1'b0);
      end else if (pick < 65) begin
         send_random_frame(pick_body_len(), 1'b1);
      end else if (pick < 72) begin
         send_item(rtu_pkg::FUNC_ARM, rtu_pkg::BYTE_W'($urandom));
         repeat ($urandom_range(1, rtu_pkg::MIN_FRAME - 1)) begin
            maybe_idle_tick();
            send_item(rtu_pkg::FUNC_BYTE, rtu_pkg::BYTE_W'($urandom));
         end
         run_out_timer();
      end else if (pick < 77) begin
         send_item(rtu_pkg::FUNC_ARM, rtu_pkg::BYTE_W'($urandom));
         run_out_timer();
      end else if (pick < 82) begin
         send_item(rtu_pkg::FUNC_ARM, rtu_pkg::BYTE_W'($urandom));
         repeat (FRAME_BUF_BYTES)
            send_item(rtu_pkg::FUNC_BYTE, rtu_pkg::BYTE_W'($urandom));
      end else if (pick < 90) begin
         // abandoned frame, re-armed by the next one
         send_item(rtu_pkg::FUNC_ARM, rtu_pkg::BYTE_W'($urandom));
         repeat ($urandom_range(1, 6))
            send_item(rtu_pkg::FUNC_BYTE, rtu_pkg::BYTE_W'($urandom));
         send_random_frame(pick_body_len(), 1'b0);
      end else begin
         // noise: any func, any byte, then let a live frame expire
         repeat ($urandom_range(1, 4))
            send_item(rtu_pkg::FUNC_W'($urandom_range(3)), rtu_pkg::BYTE_W'($urandom));
         run_out_timer();
      end
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int quota);
      int target;
      reconfigure(rtu_pkg::TICK_W'($urandom_range(1, 12)),
                  rtu_pkg::TICK_W'($urandom_range(1, 5)));
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      target = work_items + quota;
      while (work_items < target) run_random_frame();
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.func    <= rtu_pkg::FUNC_ARM;
      req_ch.rx_byte <= '0;
      csr_we         <= 1'b0;
      csr_index      <= rtu_pkg::CSR_RESP_TIMEOUT;
      csr_wdata      <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_frame_errors();
      test_good_frames();
      test_zero_ticks();
      test_overrun();
      test_register_extremes();
      test_backpressure();

      // ~330 state-changing beats over three idle profiles
      test_random_traffic(13, 79, 110);
      test_random_traffic(79, 13, 110);
      test_random_traffic(0, 0, 110);

      drain_results();
      if (frame_beats.size() != 0)
         report_mismatch($sformatf("%0d expected beats never arrived", frame_beats.size()));

      if (mismatch_count == 0) begin
         $display("rtu_response_receiver_tb: done, clean");
      end else begin
         $display("rtu_response_receiver_tb: done, errors");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("rtu_response_receiver_tb: done, errors");
      $finish;
   end

endmodule

### rtu_response_receiver.f
rtl/core/rtu_pkg.sv
rtl/core/rtu_req_if.sv
rtl/core/rtu_rsp_if.sv
rtl/core/rtu_ram.sv
rtl/core/rtu_out_reg.sv
rtl/core/rtu_response_receiver.sv
tb/rtu_response_receiver_tb.sv
